// ===== rtl/core/lsoc_pkg.sv =====
// shared types, register indexes and reset values for the light switch occupancy controller
`timescale 1ns / 1ps
`default_nettype none

package lsoc_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int TICKS_W    = 16;
  localparam int LEVEL_W    = 4;
  localparam int MODE_W     = 2;
  localparam int HOUR_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVELS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_MODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_START     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_END       = 3'd7;

  // reset values
  localparam logic [TICKS_W-1:0] RST_DEBOUNCE_LOW  = 16'd500;
  localparam logic [TICKS_W-1:0] RST_DEBOUNCE_HIGH = 16'd10;
  localparam logic [TICKS_W-1:0] RST_OFF_DELAY     = 16'd4000;
  localparam logic [TICKS_W-1:0] RST_MOVE_WINDOW   = 16'd60000;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVELS    = 4'd5;
  localparam logic [MODE_W-1:0]  RST_MOVE_MODE     = 2'd1;
  localparam logic [HOUR_W-1:0]  RST_DAY_START     = 5'd7;
  localparam logic [HOUR_W-1:0]  RST_DAY_END       = 5'd16;

  // motion modes
  localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DARK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd2;

  // beat kinds
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SET_AUTO = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_OFF    = 4'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MOTION = 4'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_FIRST  = 4'd2;

  typedef struct packed {
    logic [TICKS_W-1:0] debounce_low_ticks;
    logic [TICKS_W-1:0] debounce_high_ticks;
    logic [TICKS_W-1:0] off_delay_ticks;
    logic [TICKS_W-1:0] move_window_ticks;
    logic [LEVEL_W-1:0] max_levels;
    logic [MODE_W-1:0]  move_mode;
    logic [HOUR_W-1:0]  day_start_hour;
    logic [HOUR_W-1:0]  day_end_hour;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              auto_value;
    logic              switch_active;
    logic              motion_active;
    logic              time_valid;
    logic [HOUR_W-1:0] clock_hour;
  } item_t;

  typedef struct packed {
    logic               switch_seen;
    logic               level_changed;
    logic [LEVEL_W-1:0] light_level;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsoc_cfg_regs.sv =====
// configuration register file with write port
`timescale 1ns / 1ps
`default_nettype none

module lsoc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lsoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lsoc_pkg::CFG_W-1:0]     cfg_wdata,
  output lsoc_pkg::cfg_t                      cfg
);
  import lsoc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_low_ticks  <= RST_DEBOUNCE_LOW;
      cfg_r.debounce_high_ticks <= RST_DEBOUNCE_HIGH;
      cfg_r.off_delay_ticks     <= RST_OFF_DELAY;
      cfg_r.move_window_ticks   <= RST_MOVE_WINDOW;
      cfg_r.max_levels          <= RST_MAX_LEVELS;
      cfg_r.move_mode           <= RST_MOVE_MODE;
      cfg_r.day_start_hour      <= RST_DAY_START;
      cfg_r.day_end_hour        <= RST_DAY_END;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_LOW:  cfg_r.debounce_low_ticks  <= cfg_wdata[TICKS_W-1:0];
        REG_DEBOUNCE_HIGH: cfg_r.debounce_high_ticks <= cfg_wdata[TICKS_W-1:0];
        REG_OFF_DELAY:     cfg_r.off_delay_ticks     <= cfg_wdata[TICKS_W-1:0];
        REG_MOVE_WINDOW:   cfg_r.move_window_ticks   <= cfg_wdata[TICKS_W-1:0];
        REG_MAX_LEVELS:    cfg_r.max_levels          <= cfg_wdata[LEVEL_W-1:0];
        REG_MOVE_MODE:     cfg_r.move_mode           <= cfg_wdata[MODE_W-1:0];
        REG_DAY_START:     cfg_r.day_start_hour      <= cfg_wdata[HOUR_W-1:0];
        REG_DAY_END:       cfg_r.day_end_hour        <= cfg_wdata[HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/lsoc_state.sv =====
// controller state and the combinational update for one beat
`timescale 1ns / 1ps
`default_nettype none

module lsoc_state #(
  parameter int TIMER_BITS = lsoc_pkg::TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire lsoc_pkg::cfg_t   cfg,
  input  wire lsoc_pkg::item_t  item,
  output lsoc_pkg::result_t     res
);
  import lsoc_pkg::*;

  localparam int CMP_W = ((TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W) + 1;

  logic [TIMER_BITS-1:0] debounce_count_r, debounce_count_nxt;
  logic [TIMER_BITS-1:0] off_timer_r, off_timer_nxt;
  logic [TIMER_BITS-1:0] move_timer_r, move_timer_nxt;
  logic                  last_sample_r, last_sample_nxt;
  logic                  release_armed_r, release_armed_nxt;
  logic                  auto_off_r, auto_off_nxt;
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic [LEVEL_W-1:0]    reported_r, reported_nxt;

  logic [TIMER_BITS:0]   cnt_inc;
  logic                  hold_short;
  logic [LEVEL_W:0]      lvl_step;
  logic                  daytime;
  logic                  motion_hit;
  logic                  force_rep;
  logic [TIMER_BITS-1:0] move_load;
  logic [TIMER_BITS-1:0] off_load;

  assign cnt_inc   = {1'b0, debounce_count_r} + 1'b1;
  assign move_load = TIMER_BITS'(cfg.move_window_ticks);
  assign off_load  = TIMER_BITS'(cfg.off_delay_ticks);
  assign hold_short =
    (!item.switch_active && (CMP_W'(cnt_inc) < CMP_W'(cfg.debounce_low_ticks))) ||
    ( item.switch_active && (CMP_W'(cnt_inc) < CMP_W'(cfg.debounce_high_ticks)));
  assign daytime = item.time_valid && (item.clock_hour >= cfg.day_start_hour) &&
                   (item.clock_hour <= cfg.day_end_hour);
  assign motion_hit = (cfg.move_mode == MODE_ALWAYS) ||
                      ((cfg.move_mode == MODE_DARK) && !daytime);

  always_comb begin
    debounce_count_nxt = debounce_count_r;
    off_timer_nxt      = off_timer_r;
    move_timer_nxt     = move_timer_r;
    last_sample_nxt    = last_sample_r;
    release_armed_nxt  = release_armed_r;
    auto_off_nxt       = auto_off_r;
    level_nxt          = level_r;
    force_rep          = 1'b0;
    lvl_step           = {1'b0, level_r} + 1'b1;
    if (lvl_step == {1'b0, LEVEL_MOTION}) begin
      lvl_step = {1'b0, LEVEL_FIRST};
    end

    if (item.cmd == CMD_SET_AUTO) begin
      if (!item.auto_value) begin
        off_timer_nxt  = '0;
        move_timer_nxt = '0;
        force_rep      = 1'b1;
        level_nxt      = LEVEL_MOTION;
      end
      auto_off_nxt = item.auto_value;
      if (item.auto_value) begin
        move_timer_nxt = move_load;
      end
    end else begin
      // switch debounce and level stepping
      if (item.switch_active != last_sample_r) begin
        debounce_count_nxt = '0;
      end else if (hold_short) begin
        debounce_count_nxt = cnt_inc[TIMER_BITS-1:0];
      end else if (!item.switch_active) begin
        release_armed_nxt = 1'b1;
      end else if (release_armed_r) begin
        release_armed_nxt = 1'b0;
        if (lvl_step > {1'b0, cfg.max_levels}) begin
          level_nxt     = LEVEL_OFF;
          off_timer_nxt = off_load;
        end else begin
          level_nxt = lvl_step[LEVEL_W-1:0];
        end
      end
      last_sample_nxt = item.switch_active;

      // motion handling below switch levels
      if (level_nxt <= LEVEL_MOTION) begin
        if (off_timer_nxt != '0) begin
          off_timer_nxt = off_timer_nxt - 1'b1;
        end else if (item.motion_active) begin
          if (motion_hit) begin
            level_nxt = LEVEL_MOTION;
            if (auto_off_r) begin
              move_timer_nxt = move_load;
            end
          end
        end else if (move_timer_nxt != '0) begin
          move_timer_nxt = move_timer_nxt - 1'b1;
          if (move_timer_nxt == '0) begin
            level_nxt = LEVEL_OFF;
          end
        end
      end
    end

    reported_nxt      = level_nxt;
    res.light_level   = level_nxt;
    res.level_changed = force_rep || (reported_r != level_nxt);
    res.switch_seen   = last_sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= '0;
      off_timer_r      <= '0;
      move_timer_r     <= '0;
      last_sample_r    <= 1'b0;
      release_armed_r  <= 1'b0;
      auto_off_r       <= 1'b0;
      level_r          <= LEVEL_OFF;
      reported_r       <= LEVEL_OFF;
    end else if (advance) begin
      debounce_count_r <= debounce_count_nxt;
      off_timer_r      <= off_timer_nxt;
      move_timer_r     <= move_timer_nxt;
      last_sample_r    <= last_sample_nxt;
      release_armed_r  <= release_armed_nxt;
      auto_off_r       <= auto_off_nxt;
      level_r          <= level_nxt;
      reported_r       <= reported_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/light_switch_occupancy_controller.sv =====
// top level: input register, state update, result register, config port
//
// Light switch and occupancy controller.
// in_*  : one beat per tick or set-auto event. in_tuser is the beat kind
//         (0 tick, 1 set auto-off); in_tdata carries the sensor levels
//         and the hour.
// out_* : exactly one result beat per accepted input beat, in order,
//         carrying the light level, a changed flag and the switch state.
// cfg_* : register writes, taken at any edge with cfg_we high; write only
//         while no beat is in flight.
// Path: an accepted input beat waits in the input register, is updated, and
// its result is put on out_* by the result register.
// Throughput: 1 beat per cycle while out_tready stays high; the whole update for
// a beat is combinational, between the input register and the result register.
// Stall: when out_tready is low the result register holds, the input
// register fills, and in_tready drops until the result is taken.
// Reset: rst_n low clears the valid flags of both registers, all controller state
// (light off, timers zero, auto-off disabled) and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module light_switch_occupancy_controller #(
  parameter int TIMER_BITS = lsoc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // auto_value, switch_active, motion_active, time_valid, clock_hour[4:0], zero pad
  input  wire logic [lsoc_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // light_level[3:0], level_changed, switch_seen, zero pad
  output logic [lsoc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [lsoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsoc_pkg::CFG_W-1:0]      cfg_wdata
);
  import lsoc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    in_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    advance;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.cmd           <= in_tuser;
      item_r.auto_value    <= in_tdata[0];
      item_r.switch_active <= in_tdata[1];
      item_r.motion_active <= in_tdata[2];
      item_r.time_valid    <= in_tdata[3];
      item_r.clock_hour    <= in_tdata[4 +: HOUR_W];
    end
  end

  lsoc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsoc_state #(
    .TIMER_BITS (TIMER_BITS)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .item    (item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - LEVEL_W - 2){1'b0}}, res_r.switch_seen,
                       res_r.level_changed, res_r.light_level};

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the light switch occupancy controller
`timescale 1ns / 1ps

module testbench;
  import lsoc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 80;

  class light_level_predictor;
    cfg_t cfg = '{RST_DEBOUNCE_LOW, RST_DEBOUNCE_HIGH, RST_OFF_DELAY, RST_MOVE_WINDOW,
                  RST_MAX_LEVELS, RST_MOVE_MODE, RST_DAY_START, RST_DAY_END};
    logic [TICKS_W-1:0] debounce_count = '0;
    logic [TICKS_W-1:0] off_timer = '0;
    logic [TICKS_W-1:0] move_timer = '0;
    logic [LEVEL_W-1:0] level = LEVEL_OFF;
    logic [LEVEL_W-1:0] reported_level = LEVEL_OFF;
    bit last_sample = 1'b0;
    bit release_armed = 1'b0;
    bit auto_off = 1'b0;
    bit force_report = 1'b0;
    result_t pending_results[$];
    int errors = 0;

    function void predict_level(item_t it);
      int next_count;
      int next_level;
      result_t r;
      if (it.cmd == CMD_SET_AUTO) begin
        if (!it.auto_value) begin
          off_timer = '0;
          move_timer = '0;
          force_report = 1'b1;
          level = LEVEL_MOTION;
        end
        auto_off = it.auto_value;
        if (auto_off) move_timer = cfg.move_window_ticks;
      end else begin
        if (it.switch_active != last_sample) begin
          debounce_count = '0;
        end else begin
          next_count = int'(debounce_count) + 1;
          if ((!it.switch_active && next_count < cfg.debounce_low_ticks) ||
              (it.switch_active && next_count < cfg.debounce_high_ticks)) begin
            debounce_count = next_count[TICKS_W-1:0];
          end else if (!it.switch_active) begin
            release_armed = 1'b1;
          end else if (release_armed) begin
            release_armed = 1'b0;
            next_level = int'(level) + 1;
            if (next_level == 1) next_level++;
            if (next_level > cfg.max_levels) begin
              next_level = 0;
              off_timer = cfg.off_delay_ticks;
            end
            level = next_level[LEVEL_W-1:0];
          end
        end
        last_sample = it.switch_active;
        // motion handling only below the switch levels
        if (level <= LEVEL_MOTION) begin
          if (off_timer != 0) begin
            off_timer--;
          end else if (it.motion_active) begin
            if (cfg.move_mode == MODE_ALWAYS ||
                (cfg.move_mode == MODE_DARK &&
                 !(it.time_valid && it.clock_hour >= cfg.day_start_hour &&
                   it.clock_hour <= cfg.day_end_hour))) begin
              level = LEVEL_MOTION;
              if (auto_off) move_timer = cfg.move_window_ticks;
            end
          end else if (move_timer != 0) begin
            move_timer--;
            if (move_timer == 0) level = LEVEL_OFF;
          end
        end
      end
      r.level_changed = 1'b0;
      if (force_report || reported_level != level) begin
        reported_level = level;
        force_report = 1'b0;
        r.level_changed = 1'b1;
      end
      r.light_level = level;
      r.switch_seen = last_sample;
      pending_results.push_back(r);
    endfunction

    function void check_level(logic [OUT_DATA_W-1:0] tdata);
      result_t got;
      result_t want;
      got = result_t'(tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.light_level !== want.light_level) begin
          $display("%0t: light_level expected %0d actual %0d", $time,
                   want.light_level, got.light_level);
          errors++;
        end
        if (got.level_changed !== want.level_changed) begin
          $display("%0t: level_changed expected %0d actual %0d", $time,
                   want.level_changed, got.level_changed);
          errors++;
        end
        if (got.switch_seen !== want.switch_seen) begin
          $display("%0t: switch_seen expected %0d actual %0d", $time,
                   want.switch_seen, got.switch_seen);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  light_level_predictor levels;
  int tx_idle_pct = 24;
  int rx_idle_pct = 24;
  bit hold_off_req = 1'b0;
  int quiet = 0;

  light_switch_occupancy_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitors
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        levels.predict_level(item_t'{in_tuser, in_tdata[0], in_tdata[1], in_tdata[2],
                                     in_tdata[3], in_tdata[8:4]});
      end
      if (out_tvalid && out_tready) levels.check_level(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("[light_switch_occupancy_controller] ERROR");
    $finish;
  end

  // result side ready
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {{(IN_DATA_W-9){1'b0}}, it.clock_hour, it.time_valid, it.motion_active,
                  it.switch_active, it.auto_value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (levels.pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    write_reg(REG_DEBOUNCE_LOW, c.debounce_low_ticks);
    write_reg(REG_DEBOUNCE_HIGH, c.debounce_high_ticks);
    write_reg(REG_OFF_DELAY, c.off_delay_ticks);
    write_reg(REG_MOVE_WINDOW, c.move_window_ticks);
    write_reg(REG_MAX_LEVELS, CFG_W'(c.max_levels));
    write_reg(REG_MOVE_MODE, CFG_W'(c.move_mode));
    write_reg(REG_DAY_START, CFG_W'(c.day_start_hour));
    write_reg(REG_DAY_END, CFG_W'(c.day_end_hour));
    cfg_we <= 1'b0;
    levels.cfg = c;
  endtask

  function automatic cfg_t phase_cfg(int p);
    cfg_t c;
    c.debounce_low_ticks  = TICKS_W'($urandom_range(4));
    c.debounce_high_ticks = TICKS_W'($urandom_range(4));
    c.off_delay_ticks     = TICKS_W'($urandom_range(8));
    c.move_window_ticks   = TICKS_W'($urandom_range(10));
    c.max_levels          = LEVEL_W'($urandom_range(15, 2));
    c.move_mode           = MODE_W'($urandom_range(3));
    c.day_start_hour      = HOUR_W'($urandom_range(23));
    c.day_end_hour        = HOUR_W'($urandom_range(23));
    case (p)
      0: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, MODE_ALWAYS, 5'd31, 5'd0};
      1: c = '{16'd0, 16'd0, 16'd0, 16'd0, 4'd15, MODE_DARK, 5'd0, 5'd23};
      2: c = '{16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 4'd2, MODE_UNUSED, 5'd23, 5'd0};
      3: c.max_levels = 4'd0;
      4: begin
        c.max_levels = 4'd1;
        c.move_mode = MODE_IGNORE;
      end
      5: begin
        c.max_levels = 4'd15;
        c.debounce_low_ticks = 16'd1;
        c.debounce_high_ticks = 16'd1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // switch runs long enough to qualify most of the time, with bounce and events mixed in
  task automatic run_phase(int n);
    item_t it;
    bit level_sw;
    int run_left;
    int hold;
    level_sw = levels.last_sample;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      it.auto_value    = 1'($urandom_range(1));
      it.switch_active = 1'($urandom_range(1));
      it.motion_active = ($urandom_range(99) < 30);
      it.time_valid    = 1'($urandom_range(1));
      it.clock_hour    = HOUR_W'($urandom_range(31));
      if ($urandom_range(99) < 3) begin
        it.cmd = CMD_SET_AUTO;
      end else begin
        it.cmd = CMD_TICK;
        if (run_left == 0) begin
          level_sw = !level_sw;
          hold = level_sw ? int'(levels.cfg.debounce_high_ticks)
                          : int'(levels.cfg.debounce_low_ticks);
          if (hold > 6) hold = 6;
          if (hold < 1) hold = 1;
          run_left = ($urandom_range(99) < 70) ? hold + 1 + int'($urandom_range(1))
                                               : int'($urandom_range(hold + 2, 1));
        end
        run_left--;
        it.switch_active = level_sw ^ ($urandom_range(99) < 4);
      end
      send_beat(it);
    end
  endtask

  initial begin
    levels = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: motion lighting, set-auto events, day window
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 5'd31});
    send_beat(item_t'{CMD_SET_AUTO, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b1, 5'd10});
    send_beat(item_t'{CMD_SET_AUTO, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 5'd7});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 5'd16});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 5'd6});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 5'd31});
    send_beat(item_t'{CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31});
    drain();

    // fast debounce: step to the top level, wrap to off, off-delay, move window
    write_config('{16'd1, 16'd1, 16'd3, 16'd2, 4'd2, MODE_ALWAYS, 5'd0, 5'd23});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0});
    send_beat(item_t'{CMD_SET_AUTO, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});
    send_beat(item_t'{CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0});

    for (int p = 0; p < 11; p++) begin
      drain();
      write_config(phase_cfg(p));
      tx_idle_pct = (p == 8 || p == 9) ? 0 : 24;
      rx_idle_pct = tx_idle_pct;
      if (p == 5) hold_off_req = 1'b1;
      if (p == 7) begin
        run_phase(60);
        drain();
        run_phase(58);
      end else begin
        run_phase(p == 0 ? 40 : 118);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (levels.errors == 0 && levels.pending_results.size() == 0) begin
      $display("[light_switch_occupancy_controller] OK");
    end else begin
      $display("[light_switch_occupancy_controller] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lsoc_pkg.sv
rtl/core/lsoc_cfg_regs.sv
rtl/core/lsoc_state.sv
rtl/core/light_switch_occupancy_controller.sv
verif/testbench.sv
